>>> sv/dscmp_pkg.sv
// shared types, constants and modular arithmetic for the digit sum counter
`default_nettype none

package dscmp_pkg;

    // field widths of the stream words
    localparam int N_W = 10;
    localparam int S_W = 13;
    localparam int R_W = 30;

    // default sizes of the block
    localparam int DEF_MAX_DIGITS = 512;
    localparam int DEF_MAX_SUM    = 4096;

    // modulus and number base
    localparam logic [31:0] PRIME      = 32'd1000000007;
    localparam int          DIGIT_BASE = 10;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_FINAL,
        ST_DONE
    } t_state;

    // (a + b - c) mod prime, all operands already reduced
    function automatic logic [R_W-1:0] mod_step(input logic [R_W-1:0] a,
                                                 input logic [R_W-1:0] b,
                                                 input logic [R_W-1:0] c);
        logic [31:0] t;
        t = {2'b00, a} + {2'b00, b} - {2'b00, c};
        // result lies in (-prime, 2*prime), so bit 31 marks a negative value
        if (t[31]) begin
            mod_step = R_W'(t + PRIME);
        end else if (t >= PRIME) begin
            mod_step = R_W'(t - PRIME);
        end else begin
            mod_step = R_W'(t);
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/digit_sum_count_mod_prime.sv
// top level: counts N-digit numbers with a given digit sum, modulo 1000000007
//
// channel   dir  signals                          word
// s_        in   i_s_tvalid/o_s_tready/i_s_tdata  digit_count, digit_sum
// m_        out  o_m_tvalid/i_m_tready/o_m_tdata  count_mod
//
// the time one word takes is set by the two row banks, each read and written at
// one entry per cycle; an out-of-range word (N of 0 or above MAX_DIGITS, S above
// MAX_SUM) goes straight from idle to the done state and yields a count of zero.
// i_rst_n is synchronous and active low; the banks need no clearing pass.
// a finished result waits in the output register; the next word is taken
// while it waits, and the sequencer holds only if a second result is ready.
`default_nettype none

module digit_sum_count_mod_prime #(
    parameter int MAX_DIGITS = dscmp_pkg::DEF_MAX_DIGITS,
    parameter int MAX_SUM    = dscmp_pkg::DEF_MAX_SUM
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // [9:0] digit_count, [22:10] digit_sum, [23] zero
    input  wire logic [23:0] i_s_tdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [29:0] count_mod, [31:30] zero
    output logic      [31:0] o_m_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready
);

    localparam int DEPTH  = MAX_SUM + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_SUM + 2);
    localparam int N_W    = dscmp_pkg::N_W;
    localparam int S_W    = dscmp_pkg::S_W;
    localparam int R_W    = dscmp_pkg::R_W;
    localparam int TAPS   = dscmp_pkg::DIGIT_BASE;

    dscmp_pkg::t_state r_state, n_state;

    logic [N_W-1:0]   r_n, n_n;
    logic [N_W-1:0]   r_k, n_k;
    logic [IDX_W-1:0] r_s, n_s;
    logic [IDX_W-1:0] r_lo, n_lo;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [R_W-1:0]   r_acc, n_acc;
    logic [R_W-1:0]   r_taps [TAPS];
    logic [R_W-1:0]   n_taps [TAPS];
    logic             r_sel, n_sel;
    logic             r_out_vld, n_out_vld;
    logic [R_W-1:0]   r_out_data, n_out_data;

    logic [N_W-1:0]    in_n;
    logic [S_W-1:0]    in_s;
    logic              in_bad;
    logic              out_free;
    logic [R_W-1:0]    step_val;
    logic [R_W-1:0]    rd_prev;
    logic [R_W-1:0]    rdata_a, rdata_b;
    logic              we_prev, we_next;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [R_W-1:0]    wdata;
    logic              we_a, we_b;

    // input word fields and range check
    assign in_n   = i_s_tdata[N_W-1:0];
    assign in_s   = i_s_tdata[N_W+S_W-1:N_W];
    assign in_bad = (in_n == '0) || (32'(in_n) > 32'(MAX_DIGITS))
                 || (32'(in_s) > 32'(MAX_SUM));

    assign out_free = !r_out_vld || i_m_tready;
    assign rd_prev  = r_sel ? rdata_b : rdata_a;

    // prev bank is a when r_sel is low
    assign we_a = (we_prev && !r_sel) || (we_next && r_sel);
    assign we_b = (we_prev && r_sel) || (we_next && !r_sel);

    dscmp_ram #(.DEPTH(DEPTH), .WIDTH(R_W)) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_a)
    );

    dscmp_ram #(.DEPTH(DEPTH), .WIDTH(R_W)) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_b)
    );

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dscmp_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_k        <= n_k;
        r_s        <= n_s;
        r_lo       <= n_lo;
        r_idx      <= n_idx;
        r_acc      <= n_acc;
        r_taps     <= n_taps;
        r_sel      <= n_sel;
        r_out_data <= n_out_data;
    end

    // sliding window step: add the new entry; during a row sweep also drop the one ten places back
    always_comb begin
        if (r_state == dscmp_pkg::ST_ROW) begin
            step_val = dscmp_pkg::mod_step(r_acc, rd_prev, r_taps[TAPS-1]);
        end else begin
            step_val = dscmp_pkg::mod_step(r_acc, rd_prev, '0);
        end
    end

    // sequencer: next state, bank accesses and result
    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_k        = r_k;
        n_s        = r_s;
        n_lo       = r_lo;
        n_idx      = r_idx;
        n_acc      = r_acc;
        n_taps     = r_taps;
        n_sel      = r_sel;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out_data = r_out_data;
        o_s_tready = 1'b0;
        we_prev    = 1'b0;
        we_next    = 1'b0;
        waddr      = r_idx[ADDR_W-1:0];
        wdata      = '0;
        raddr      = '0;

        case (r_state)
            dscmp_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_n   = in_n;
                    n_s   = IDX_W'(in_s);
                    n_lo  = (IDX_W'(in_s) >= IDX_W'(9)) ? IDX_W'(in_s) - IDX_W'(9) : '0;
                    n_idx = '0;
                    n_acc = '0;
                    n_sel = 1'b0;
                    n_k   = N_W'(1);
                    if (in_bad) begin
                        n_state = dscmp_pkg::ST_DONE;
                    end else begin
                        n_state = dscmp_pkg::ST_INIT;
                    end
                end
            end

            // row zero: one at sum zero, zero elsewhere
            dscmp_pkg::ST_INIT: begin
                we_prev = 1'b1;
                waddr   = r_idx[ADDR_W-1:0];
                wdata   = (r_idx == '0) ? R_W'(1) : '0;
                n_idx   = r_idx + IDX_W'(1);
                if (r_idx == r_s) begin
                    n_acc = '0;
                    for (int i = 0; i < TAPS; i++) begin
                        n_taps[i] = '0;
                    end
                    if (r_n == N_W'(1)) begin
                        n_idx   = r_lo;
                        n_state = dscmp_pkg::ST_FINAL;
                    end else begin
                        n_idx   = '0;
                        n_state = dscmp_pkg::ST_ROW;
                    end
                end
            end

            // one row: read prev entry j, write next entry j-1
            dscmp_pkg::ST_ROW: begin
                raddr = (r_idx <= r_s) ? r_idx[ADDR_W-1:0] : '0;
                waddr = ADDR_W'(r_idx - IDX_W'(1));
                wdata = step_val;
                if (r_idx != '0) begin
                    we_next   = 1'b1;
                    n_acc     = step_val;
                    n_taps[0] = rd_prev;
                    for (int i = 1; i < TAPS; i++) begin
                        n_taps[i] = r_taps[i-1];
                    end
                end
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == r_s + IDX_W'(1)) begin
                    n_sel = !r_sel;
                    n_acc = '0;
                    for (int i = 0; i < TAPS; i++) begin
                        n_taps[i] = '0;
                    end
                    if (r_k == r_n - N_W'(1)) begin
                        n_idx   = r_lo;
                        n_state = dscmp_pkg::ST_FINAL;
                    end else begin
                        n_idx = '0;
                        n_k   = r_k + N_W'(1);
                    end
                end
            end

            // leading digits 1 to 9: add prev entries S-9 .. S-1
            dscmp_pkg::ST_FINAL: begin
                raddr = r_idx[ADDR_W-1:0];
                if (r_idx != r_lo) begin
                    n_acc = step_val;
                end
                if (r_idx == r_s) begin
                    n_state = dscmp_pkg::ST_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // hand the result to the output register
            dscmp_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_data = r_acc;
                    n_state    = dscmp_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = dscmp_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out_data};

    // row counter stays below the digit count
    a_row_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dscmp_pkg::ST_ROW) |-> (r_k < r_n))
        else $error("row counter ran past digit count");

    // sweep index never passes one beyond the target sum
    a_row_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dscmp_pkg::ST_ROW) |-> (r_idx <= r_s + IDX_W'(1)))
        else $error("row sweep index out of range");

    // running sum always reduced during the row and final sweeps
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dscmp_pkg::ST_ROW || r_state == dscmp_pkg::ST_FINAL)
        |-> (32'(r_acc) < dscmp_pkg::PRIME))
        else $error("running sum not reduced");

    // an accepted word starts work
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state != dscmp_pkg::ST_IDLE))
        else $error("accepted word did not start the sequencer");

    // a presented result is always reduced
    a_out_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata < dscmp_pkg::PRIME))
        else $error("result not reduced");

endmodule

`default_nettype wire

>>> sv/dscmp_ram.sv
// single write, single read synchronous row memory with a registered read port
`default_nettype none

module dscmp_ram #(
    parameter int DEPTH = dscmp_pkg::DEF_MAX_SUM + 1,
    parameter int WIDTH = dscmp_pkg::R_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// testbench for the digit sum counter: directed and random words checked against a predictor
`timescale 1ns / 100ps

module testbench;

    // sizes of the stimulus and of the run
    localparam int RANDOM_WORDS = 80;
    localparam int IDLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES = 40;

    // expected counts of accepted words, checked in order
    class count_ledger;
        logic [dscmp_pkg::R_W-1:0] counts_due[$];
        int                        errors;

        function new();
            errors = 0;
        endfunction

        // N-digit numbers, leading digit nonzero, with digit sum s, modulo the prime
        function logic [dscmp_pkg::R_W-1:0] count_numbers(int unsigned n, int unsigned s);
            longint unsigned ways[];
            longint unsigned ways_next[];
            longint unsigned window;
            longint unsigned total;
            if (n == 0 || n > dscmp_pkg::DEF_MAX_DIGITS || s > dscmp_pkg::DEF_MAX_SUM) begin
                return '0;
            end
            ways      = new[s + 1];
            ways_next = new[s + 1];
            foreach (ways[j]) begin
                ways[j] = (j == 0) ? 1 : 0;
            end
            // strings of k digits, leading zeros allowed: sliding window of ten
            for (int k = 1; k < n; k++) begin
                window = 0;
                for (int j = 0; j <= s; j++) begin
                    window = (window + ways[j]) % dscmp_pkg::PRIME;
                    if (j >= dscmp_pkg::DIGIT_BASE) begin
                        window = (window + dscmp_pkg::PRIME
                                  - ways[j - dscmp_pkg::DIGIT_BASE]) % dscmp_pkg::PRIME;
                    end
                    ways_next[j] = window;
                end
                ways = ways_next;
            end
            // leading digit 1 to 9 in front of the remaining n-1 digits
            total = 0;
            for (int d = 1; d < dscmp_pkg::DIGIT_BASE; d++) begin
                if (d <= s) begin
                    total = (total + ways[s - d]) % dscmp_pkg::PRIME;
                end
            end
            return dscmp_pkg::R_W'(total);
        endfunction

        function void note_word(logic [dscmp_pkg::N_W-1:0] n, logic [dscmp_pkg::S_W-1:0] s);
            counts_due.push_back(count_numbers(n, s));
        endfunction

        function int outstanding();
            return counts_due.size();
        endfunction

        task flag_mismatch(string what);
            errors++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_count(logic [31:0] word);
            logic [dscmp_pkg::R_W-1:0] want;
            if (counts_due.size() == 0) begin
                flag_mismatch($sformatf("count word 0x%08h with no word outstanding", word));
                return;
            end
            want = counts_due.pop_front();
            if (word[dscmp_pkg::R_W-1:0] !== want) begin
                flag_mismatch($sformatf("count_mod %0d, expected %0d",
                                        word[dscmp_pkg::R_W-1:0], want));
            end
            if (word[31:dscmp_pkg::R_W] !== '0) begin
                flag_mismatch($sformatf("pad bits of count word are %b",
                                        word[31:dscmp_pkg::R_W]));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic [23:0] i_s_tdata;   // [9:0] digit_count, [22:10] digit_sum, [23] zero
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] o_m_tdata;   // [29:0] count_mod, [31:30] zero
    logic        o_m_tvalid;
    logic        i_m_tready;

    count_ledger ledger = new();
    bit          calm;
    int          idle_cycles = 0;

    digit_sum_count_mod_prime uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // gap length: mostly none or short, now and then long; none during calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // present one word after a random gap and hold it until taken
    task automatic send_word(input logic [dscmp_pkg::N_W-1:0] n,
                             input logic [dscmp_pkg::S_W-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, s, n};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // handshake monitor and idle counter
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                ledger.note_word(i_s_tdata[dscmp_pkg::N_W-1:0],
                                 i_s_tdata[dscmp_pkg::N_W+dscmp_pkg::S_W-1:dscmp_pkg::N_W]);
            end
            if (o_m_tvalid && i_m_tready) begin
                ledger.check_count(o_m_tdata);
            end
        end
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    initial begin
        @(posedge i_clk);
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // result side back-pressure
    initial begin
        int stall;
        i_m_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge i_clk) i_m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_m_tready <= 1'b1;
        end
    end

    // stimulus and end of run
    initial begin
        logic [dscmp_pkg::N_W-1:0] n;
        logic [dscmp_pkg::S_W-1:0] s;
        int                        pick;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        calm       = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // zero digits, too many digits, sum too large
        send_word(10'd0, 13'd5);
        send_word(10'd0, 13'd0);
        send_word(10'd513, 13'd10);
        send_word(10'd1023, 13'd8191);
        send_word(10'd5, 13'd4097);
        send_word(10'd3, 13'd8191);
        // single digit, sum zero unreachable
        send_word(10'd1, 13'd0);
        send_word(10'd1, 13'd1);
        send_word(10'd1, 13'd9);
        send_word(10'd1, 13'd10);
        // sums at and just above nine per digit, and one low sum
        send_word(10'd2, 13'd18);
        send_word(10'd2, 13'd19);
        send_word(10'd3, 13'd27);
        send_word(10'd2, 13'd1);
        // largest sum with few digits
        send_word(10'd1, 13'd4096);
        send_word(10'd3, 13'd4096);
        // largest digit count
        send_word(10'd512, 13'd0);
        send_word(10'd512, 13'd1);
        send_word(10'd512, 13'd160);
        // counts that wrap the modulus
        send_word(10'd20, 13'd90);
        send_word(10'd40, 13'd180);

        // random words, mostly small and well formed
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 16 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // out of range in one way or another
                case ($urandom_range(0, 2))
                    0: begin
                        n = '0;
                        s = dscmp_pkg::S_W'($urandom);
                    end
                    1: begin
                        n = dscmp_pkg::N_W'($urandom_range(dscmp_pkg::DEF_MAX_DIGITS + 1, 1023));
                        s = dscmp_pkg::S_W'($urandom);
                    end
                    default: begin
                        n = dscmp_pkg::N_W'($urandom_range(1, 30));
                        s = dscmp_pkg::S_W'($urandom_range(dscmp_pkg::DEF_MAX_SUM + 1, 8191));
                    end
                endcase
            end else if (pick < 16) begin
                n = dscmp_pkg::N_W'($urandom_range(25, dscmp_pkg::DEF_MAX_DIGITS));
                s = dscmp_pkg::S_W'($urandom_range(0, 40));
            end else if (pick < 22) begin
                n = dscmp_pkg::N_W'($urandom_range(1, 3));
                s = dscmp_pkg::S_W'($urandom_range(0, dscmp_pkg::DEF_MAX_SUM));
            end else begin
                n = dscmp_pkg::N_W'($urandom_range(1, 24));
                s = dscmp_pkg::S_W'($urandom_range(0, 9 * n + 3));
            end
            send_word(n, s);
        end
        @(negedge i_clk) i_s_tvalid <= 1'b0;

        // wait for every count, then watch for strays
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
